### src/lqbm_pkg.sv
// types and constants shared by the linked queue buffer manager
// no dependencies; imported by lqbm_ctrl, lqbm_dp and the top level
`default_nettype none

package lqbm_pkg;

  localparam int unsigned PoolCountW = 9;

  typedef enum logic [2:0] {
    REQ_REBUILD = 3'd0,
    REQ_ALLOC   = 3'd1,
    REQ_FREE    = 3'd2,
    REQ_PUSH    = 3'd3,
    REQ_POP     = 3'd4,
    REQ_CLEAR   = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EXHAUSTED = 2'd1,
    STS_POP_EMPTY = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_POP,
    ST_TAIL,
    ST_REBUILD
  } state_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [3:0] queue_id;
    logic [7:0] node_index;
  } in_word_t;

  typedef struct packed {
    logic [7:0] result_node;
    logic       node_valid;
    logic       push_to_empty;
    logic [1:0] status;
    logic       queue_empty;
    logic [7:0] queue_head;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic exec;
    logic pop_fin;
    logic tail_fin;
    logic rb_step;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    req_e req;
    logic rb_none;
    logic rb_last;
    logic pop_hit;
    logic push_tail;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

### src/lqbm_ctrl.sv
// request sequencer of the linked queue buffer manager
// depends on lqbm_pkg; drives lqbm_dp through cmd_t and reads stat_t
`default_nettype none

module lqbm_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  input  wire logic [2:0]     in_req_i,
  output logic                in_stall_o,
  input  wire lqbm_pkg::stat_t stat_i,
  output lqbm_pkg::cmd_t      cmd_o
);
  import lqbm_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if ((req_e'(in_req_i) == REQ_REBUILD) && !stat_i.rb_none) begin
            state_d = ST_REBUILD;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        if (stat_i.out_free) begin
          cmd_o.exec = 1'b1;
          if ((stat_i.req == REQ_POP) && stat_i.pop_hit) begin
            state_d = ST_POP;
          end else if ((stat_i.req == REQ_PUSH) && stat_i.push_tail) begin
            state_d = ST_TAIL;
          end else begin
            cmd_o.out_load = 1'b1;
            state_d        = ST_IDLE;
          end
        end
      end
      ST_POP: begin
        if (stat_i.out_free) begin
          cmd_o.pop_fin  = 1'b1;
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (stat_i.out_free) begin
          cmd_o.tail_fin = 1'b1;
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      ST_REBUILD: begin
        if (!stat_i.rb_last) begin
          cmd_o.rb_step = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.rb_step  = 1'b1;
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/lqbm_dp.sv
// datapath of the linked queue buffer manager: link memory, queue tables,
// free head, rebuild counter and output register; depends on lqbm_pkg
`default_nettype none

module lqbm_dp #(
  parameter int unsigned NODES  = 256,
  parameter int unsigned QUEUES = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire lqbm_pkg::in_word_t      in_word_i,
  input  wire logic                    cfg_we_i,
  input  wire logic [lqbm_pkg::PoolCountW-1:0] cfg_wdata_i,
  input  wire lqbm_pkg::cmd_t          cmd_i,
  output lqbm_pkg::stat_t              stat_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output lqbm_pkg::out_word_t          out_word_o
);
  import lqbm_pkg::*;

  localparam int unsigned AW = $clog2(NODES);
  localparam int unsigned LW = $clog2(NODES + 1);
  localparam int unsigned QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int unsigned NW = (LW > 8) ? LW : 8;
  localparam int unsigned CW = (LW > PoolCountW) ? LW : PoolCountW;
  localparam logic [LW-1:0] NullL = LW'(NODES);

  // link memory
  logic [LW-1:0] link_mem [NODES];
  logic [LW-1:0] link_rd_q;
  logic          lk_we, lk_re;
  logic [AW-1:0] lk_waddr, lk_raddr;
  logic [LW-1:0] lk_wdata;

  // queue tables
  logic [LW-1:0] qf_mem [QUEUES];
  logic [LW-1:0] ql_mem [QUEUES];
  logic [QUEUES-1:0] qf_vld_q;
  logic [LW-1:0] qf_rd_q, ql_rd_q;
  logic          qf_rd_vld_q;
  logic          qf_we, ql_we;
  logic [LW-1:0] qf_wdata;
  logic [QW-1:0] qa_in, qa_q;

  // request and control registers
  logic [2:0]    req_q;
  logic [3:0]    qid_q;
  logic [7:0]    node_q;
  logic          q_ok_q, node_ok_q;
  logic [LW-1:0] free_head_q, free_head_d;
  logic [PoolCountW-1:0] pool_count_q;
  logic [AW-1:0] rb_idx_q, rb_end_q;
  logic          out_valid_q;
  out_word_t     out_q, res_d;

  logic [CW-1:0] pool_ext, rb_n;
  logic [LW-1:0] qf_cur, node_l, new_first, res_node_l;
  logic          fh_is_node, qf_is_node, ql_is_node, rb_last, pop_hit, out_free;
  logic          q_empty;

  assign qa_in      = QW'(in_word_i.queue_id);
  assign qa_q       = QW'(qid_q);
  assign node_l     = LW'(node_q);
  assign qf_cur     = qf_rd_vld_q ? qf_rd_q : NullL;
  assign fh_is_node = free_head_q < NullL;
  assign qf_is_node = qf_cur < NullL;
  assign ql_is_node = ql_rd_q < NullL;
  assign rb_last    = rb_idx_q == rb_end_q;
  assign pop_hit    = q_ok_q && qf_is_node;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign pool_ext   = CW'(pool_count_q);
  assign rb_n       = (pool_ext > CW'(NODES)) ? CW'(NODES) : pool_ext;

  assign stat_o.req       = req_e'(req_q);
  assign stat_o.rb_none   = pool_count_q == '0;
  assign stat_o.rb_last   = rb_last;
  assign stat_o.pop_hit   = pop_hit;
  assign stat_o.push_tail = q_ok_q && node_ok_q && qf_is_node && ql_is_node;
  assign stat_o.out_free  = out_free;

  // memory ports and free head
  always_comb begin
    lk_we       = 1'b0;
    lk_waddr    = AW'(node_q);
    lk_wdata    = NullL;
    lk_re       = 1'b0;
    lk_raddr    = AW'(free_head_q);
    qf_we       = 1'b0;
    ql_we       = 1'b0;
    qf_wdata    = node_l;
    free_head_d = free_head_q;
    if (cmd_i.accept) begin
      lk_re = 1'b1;
    end
    if (cmd_i.exec) begin
      unique case (req_e'(req_q))
        REQ_ALLOC: begin
          if (fh_is_node) begin
            free_head_d = link_rd_q;
          end
        end
        REQ_FREE: begin
          if (node_ok_q) begin
            lk_we       = 1'b1;
            lk_wdata    = free_head_q;
            free_head_d = node_l;
          end
        end
        REQ_PUSH: begin
          if (node_ok_q && q_ok_q) begin
            lk_we = 1'b1;
            ql_we = 1'b1;
            qf_we = !qf_is_node;
          end
        end
        REQ_POP: begin
          lk_re    = pop_hit;
          lk_raddr = AW'(qf_cur);
        end
        REQ_CLEAR: begin
          qf_we    = q_ok_q;
          qf_wdata = NullL;
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.pop_fin) begin
      qf_we    = 1'b1;
      qf_wdata = link_rd_q;
    end
    if (cmd_i.tail_fin) begin
      lk_we    = 1'b1;
      lk_waddr = AW'(ql_rd_q);
      lk_wdata = node_l;
    end
    if (cmd_i.rb_step) begin
      lk_we    = 1'b1;
      lk_waddr = rb_idx_q;
      lk_wdata = rb_last ? NullL : (LW'(rb_idx_q) + LW'(1));
      if (rb_last) begin
        free_head_d = '0;
      end
    end
  end

  // result word
  always_comb begin
    res_node_l = '0;
    new_first  = qf_cur;
    res_d      = '0;
    res_d.status = STS_OK;
    if (cmd_i.exec) begin
      unique case (req_e'(req_q))
        REQ_ALLOC: begin
          if (fh_is_node) begin
            res_node_l       = free_head_q;
            res_d.node_valid = 1'b1;
          end else begin
            res_d.status = STS_EXHAUSTED;
          end
        end
        REQ_PUSH: begin
          if (node_ok_q && q_ok_q && !qf_is_node) begin
            res_d.push_to_empty = 1'b1;
            new_first           = node_l;
          end
        end
        REQ_POP: begin
          if (!pop_hit) begin
            res_d.status = STS_POP_EMPTY;
          end
        end
        REQ_CLEAR: begin
          if (q_ok_q) begin
            new_first = NullL;
          end
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.pop_fin) begin
      res_node_l       = qf_cur;
      res_d.node_valid = 1'b1;
      new_first        = link_rd_q;
    end
    q_empty           = !(q_ok_q && (new_first < NullL));
    res_d.result_node = 8'(res_node_l);
    res_d.queue_empty = q_empty;
    res_d.queue_head  = q_empty ? 8'd0 : 8'(new_first);
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q  <= NullL;
      pool_count_q <= '0;
      qf_vld_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      free_head_q <= free_head_d;
      if (cfg_we_i) begin
        pool_count_q <= cfg_wdata_i;
      end
      if (qf_we) begin
        qf_vld_q[qa_q] <= 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request capture, rebuild counter, output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q     <= in_word_i.req_type;
      qid_q     <= in_word_i.queue_id;
      node_q    <= in_word_i.node_index;
      q_ok_q    <= 9'(in_word_i.queue_id) < 9'(QUEUES);
      node_ok_q <= NW'(in_word_i.node_index) < NW'(NODES);
      rb_idx_q  <= '0;
      rb_end_q  <= AW'(rb_n - CW'(1));
    end else if (cmd_i.rb_step) begin
      rb_idx_q <= rb_idx_q + AW'(1);
    end
    if (cmd_i.out_load) begin
      out_q <= res_d;
    end
  end

  // link memory
  always_ff @(posedge clk_i) begin
    if (lk_we) begin
      link_mem[lk_waddr] <= lk_wdata;
    end
    if (lk_re) begin
      link_rd_q <= link_mem[lk_raddr];
    end
  end

  // queue tables, read at accept
  always_ff @(posedge clk_i) begin
    if (qf_we) begin
      qf_mem[qa_q] <= qf_wdata;
    end
    if (ql_we) begin
      ql_mem[qa_q] <= node_l;
    end
    if (cmd_i.accept) begin
      qf_rd_q     <= qf_mem[qa_in];
      ql_rd_q     <= ql_mem[qa_in];
      qf_rd_vld_q <= qf_vld_q[qa_in];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

### src/linked_queue_buffer_manager.sv
// Node pool with one free list and QUEUES singly linked FIFO queues,
// addressed by node index. Each word in gives one word out. Push onto
// and pop of a non-empty queue add state ST_TAIL or ST_POP, since they
// need a second access to the link memory (one write port, registered
// read). A rebuild writes min(pool_count, NODES) link entries, one per
// cycle, the last once the output is free; with pool_count 0 it runs
// like an unused request type. A stalled output holds a request only
// while the previous word is still held. The link memory and queue
// tables need no clearing pass after reset.
// depends on lqbm_pkg, lqbm_ctrl and lqbm_dp
`default_nettype none

module linked_queue_buffer_manager #(
  parameter int unsigned NODES  = 256,
  parameter int unsigned QUEUES = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire lqbm_pkg::in_word_t   in_word_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output lqbm_pkg::out_word_t       out_word_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [lqbm_pkg::PoolCountW-1:0] cfg_wdata_i
);
  import lqbm_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  lqbm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_word_i.req_type),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lqbm_dp #(
    .NODES  (NODES),
    .QUEUES (QUEUES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
